### rtl/hed_pkg.sv
`default_nettype none

package hed_pkg;

	localparam int MAX_SPAN_DEF = 8;
	localparam int NUM_LATIN1 = 96;
	localparam int NUM_EXTRA = 11;
	localparam int NUM_NAMES = NUM_LATIN1 + NUM_EXTRA;
	localparam int NAME_CHARS = 6;
	localparam int QDEPTH = 2;

	localparam logic [15:0] LATIN1_BASE = 16'd160;
	localparam logic [16:0] NUM_LIMIT = 17'h0FFFE;
	localparam logic [19:0] NUM_SAT = 20'h10000;

	localparam logic [15:0] CH_AMP = 16'h0026;
	localparam logic [15:0] CH_SEMI = 16'h003B;
	localparam logic [15:0] CH_HASH = 16'h0023;
	localparam logic [15:0] CH_PLUS = 16'h002B;
	localparam logic [15:0] CH_MINUS = 16'h002D;
	localparam logic [15:0] CH_ZERO = 16'h0030;
	localparam logic [15:0] CH_NINE = 16'h0039;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_TAB = 16'h0009;
	localparam logic [15:0] CH_CR = 16'h000D;

	localparam logic [8*NAME_CHARS-1:0] NAME_TBL [NUM_NAMES] = '{
		"nbsp", "iexcl", "cent", "pound", "curren", "yen", "brvbar", "sect", "uml", "copy",
		"ordf", "laquo", "not", "shy", "reg", "macr", "deg", "plusmn", "sup2", "sup3",
		"acute", "micro", "para", "middot", "cedil", "sup1", "ordm", "raquo", "frac14",
		"frac12", "frac34", "iquest", "Agrave", "Aacute", "Acirc", "Atilde", "Auml",
		"Aring", "AElig", "Ccedil", "Egrave", "Eacute", "Ecirc", "Euml", "Igrave",
		"Iacute", "Icirc", "Iuml", "ETH", "Ntilde", "Ograve", "Oacute", "Ocirc",
		"Otilde", "Ouml", "times", "Oslash", "Ugrave", "Uacute", "Ucirc", "Uuml",
		"Yacute", "THORN", "szlig", "agrave", "aacute", "acirc", "atilde", "auml",
		"aring", "aelig", "ccedil", "egrave", "eacute", "ecirc", "euml", "igrave",
		"iacute", "icirc", "iuml", "eth", "ntilde", "ograve", "oacute", "ocirc",
		"otilde", "ouml", "divide", "oslash", "ugrave", "uacute", "ucirc", "uuml",
		"yacute", "thorn", "yuml",
		"quot", "amp", "apos", "lt", "rt", "ndash", "mdash", "laquo", "raquo",
		"lsquo", "rsquo"
	};

	localparam logic [15:0] EXTRA_CODE [NUM_EXTRA] = '{
		16'd34, 16'd38, 16'd39, 16'd60, 16'd62, 16'd8211, 16'd8212, 16'd34, 16'd34,
		16'd8216, 16'd8217
	};

	typedef struct packed {
		logic        flush;
		logic        clear;
		logic        store;
		logic        emit;
		logic        last;
		logic        rep;
		logic [15:0] ch;
	} hed_cmd_t;

	function automatic int name_len(input int idx);
		int l;
		l = 0;
		for (int b = 0; b < NAME_CHARS; b++) begin
			if (NAME_TBL[idx][8*b +: 8] != 8'd0) l = b + 1;
		end
		return l;
	endfunction

	function automatic logic [7:0] name_char(input int idx, input int k);
		int l;
		l = name_len(idx);
		if (k < 0 || k >= l) return 8'd0;
		return NAME_TBL[idx][8*(l-1-k) +: 8];
	endfunction

	function automatic logic [15:0] name_code(input int idx);
		if (idx < NUM_LATIN1) return LATIN1_BASE + 16'(idx);
		return EXTRA_CODE[idx - NUM_LATIN1];
	endfunction

endpackage

`default_nettype wire

### rtl/hed_in_if.sv
`default_nettype none

interface hed_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_in;
	logic        stream_end_in;

	modport source (output valid, output char_in, output stream_end_in, input ready);
	modport sink (input valid, input char_in, input stream_end_in, output ready);
endinterface

`default_nettype wire

### rtl/hed_out_if.sv
`default_nettype none

interface hed_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_out;
	logic        was_replaced;
	logic        run_end;
	logic        stream_end_out;

	modport source (output valid, output char_out, output was_replaced, output run_end,
		output stream_end_out, input ready);
	modport sink (input valid, input char_out, input was_replaced, input run_end,
		input stream_end_out, output ready);
endinterface

`default_nettype wire

### rtl/hed_front.sv
`default_nettype none

module hed_front #(
	parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	hed_in_if.sink                in_ch,
	output hed_pkg::hed_cmd_t     cmd,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready
);
	import hed_pkg::*;

	localparam int CW = $clog2(MAX_SPAN + 1);

	typedef enum logic [1:0] {PH_LEAD, PH_DIG, PH_STOP} ph_t;

	logic [CW-1:0]        cnt_q, cnt_d;
	logic                 inref_q, inref_d;
	logic [NUM_NAMES-1:0] alive_q, alive_d;
	logic                 isnum_q, isnum_d;
	logic                 neg_q, neg_d;
	logic [16:0]          val_q, val_d;
	ph_t                  ph_q, ph_d;

	logic [15:0] c;
	logic        last, acc;
	logic        is_amp, is_semi, is_dig, is_spc, is_sign;
	logic [CW-1:0] body_len;
	logic        name_hit, dec_ok;
	logic [15:0] name_val;
	logic [19:0] prod;
	int          k;

	assign c = in_ch.char_in;
	assign last = in_ch.stream_end_in;
	assign cmd_valid = in_ch.valid;
	assign in_ch.ready = cmd_ready;
	assign acc = in_ch.valid && cmd_ready;

	always_comb begin
		is_amp = c == CH_AMP;
		is_semi = c == CH_SEMI;
		is_dig = c >= CH_ZERO && c <= CH_NINE;
		is_spc = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		is_sign = c == CH_PLUS || c == CH_MINUS;
		body_len = cnt_q - CW'(1);
		k = int'(cnt_q) - 1;
		prod = 20'(val_q) * 20'd10 + 20'(c - CH_ZERO);
		name_hit = 1'b0;
		name_val = '0;
		for (int i = NUM_NAMES - 1; i >= 0; i--) begin
			if (alive_q[i] && body_len == CW'(name_len(i))) begin
				name_hit = 1'b1;
				name_val = name_code(i);
			end
		end
		dec_ok = isnum_q ? (!neg_q && val_q != '0 && val_q < NUM_LIMIT) : name_hit;

		cmd = '0;
		cmd.ch = c;
		cmd.last = last;
		cnt_d = cnt_q;
		inref_d = inref_q;
		alive_d = alive_q;
		isnum_d = isnum_q;
		neg_d = neg_q;
		val_d = val_q;
		ph_d = ph_q;

		if (inref_q && is_semi) begin
			if (dec_ok) begin
				cmd.clear = 1'b1;
				cmd.rep = 1'b1;
				cmd.ch = isnum_q ? val_q[15:0] : name_val;
			end else begin
				cmd.flush = 1'b1;
			end
			cmd.emit = 1'b1;
			cnt_d = '0;
			inref_d = 1'b0;
		end else if (is_amp) begin
			cmd.flush = inref_q;
			cmd.store = 1'b1;
			cnt_d = CW'(1);
			inref_d = 1'b1;
			alive_d = '1;
			isnum_d = 1'b0;
		end else if (inref_q && cnt_q >= CW'(MAX_SPAN)) begin
			cmd.flush = 1'b1;
			cmd.emit = 1'b1;
			cnt_d = '0;
			inref_d = 1'b0;
		end else if (inref_q) begin
			cmd.store = 1'b1;
			cnt_d = cnt_q + CW'(1);
			for (int i = 0; i < NUM_NAMES; i++) begin
				alive_d[i] = alive_q[i] && name_char(i, k) != 8'd0 && c[15:8] == 8'd0
					&& name_char(i, k) == c[7:0];
			end
			if (cnt_q == CW'(1)) begin
				isnum_d = c == CH_HASH;
				neg_d = 1'b0;
				val_d = '0;
				ph_d = PH_LEAD;
			end else if (isnum_q) begin
				case (ph_q)
					PH_LEAD: begin
						if (is_sign) begin
							neg_d = c == CH_MINUS;
							ph_d = PH_DIG;
						end else if (is_dig) begin
							val_d = 17'(c - CH_ZERO);
							ph_d = PH_DIG;
						end else if (!is_spc) begin
							ph_d = PH_STOP;
						end
					end
					PH_DIG: begin
						if (is_dig) val_d = (prod > NUM_SAT) ? 17'(NUM_SAT) : prod[16:0];
						else ph_d = PH_STOP;
					end
					default: ph_d = PH_STOP;
				endcase
			end
		end else begin
			cmd.emit = 1'b1;
		end

		if (last) begin
			cnt_d = '0;
			inref_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			inref_q <= 1'b0;
			alive_q <= '0;
			isnum_q <= 1'b0;
			neg_q <= 1'b0;
			val_q <= '0;
			ph_q <= PH_LEAD;
		end else if (acc) begin
			cnt_q <= cnt_d;
			inref_q <= inref_d;
			alive_q <= alive_d;
			isnum_q <= isnum_d;
			neg_q <= neg_d;
			val_q <= val_d;
			ph_q <= ph_d;
		end
	end

endmodule

`default_nettype wire

### rtl/hed_queue.sv
`default_nettype none

module hed_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hed_pkg::hed_cmd_t wr_cmd,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	output hed_pkg::hed_cmd_t      rd_cmd,
	output logic                   rd_valid,
	input  wire logic              rd_pop
);
	import hed_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	hed_cmd_t        ent_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = cnt_q != (PW+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd = ent_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/hed_back.sv
`default_nettype none

module hed_back #(
	parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hed_pkg::hed_cmd_t q_cmd,
	input  wire logic              q_valid,
	output logic                   q_pop,
	hed_out_if.source              out_ch
);
	import hed_pkg::*;

	localparam int CW = $clog2(MAX_SPAN + 1);
	localparam int IW = $clog2(MAX_SPAN);

	typedef enum logic [2:0] {B_IDLE, B_FL1, B_STORE, B_EMIT, B_FL2} b_state_t;

	b_state_t      st_q;
	hed_cmd_t      cur_q;
	logic [15:0]   hold_q [MAX_SPAN];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          ov_q;
	logic [15:0]   och_q;
	logic          orep_q, oend_q, ose_q;
	logic          out_free, last_item;
	logic          ov_set;

	assign out_free = !ov_q || out_ch.ready;
	assign last_item = CW'(idx_q) + CW'(1) == cnt_q;
	assign q_pop = st_q == B_IDLE && q_valid;
	assign ov_set = out_free && (st_q inside {B_FL1, B_EMIT, B_FL2});

	assign out_ch.valid = ov_q;
	assign out_ch.char_out = och_q;
	assign out_ch.was_replaced = orep_q;
	assign out_ch.run_end = oend_q;
	assign out_ch.stream_end_out = ose_q;

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (q_valid && q_cmd.store && !(q_cmd.flush && cnt_q != '0)) begin
					hold_q[q_cmd.flush ? IW'(0) : cnt_q[IW-1:0]] <= q_cmd.ch;
				end
			end
			B_STORE: hold_q[0] <= cur_q.ch;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			cur_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			ov_q <= 1'b0;
			och_q <= '0;
			orep_q <= 1'b0;
			oend_q <= 1'b0;
			ose_q <= 1'b0;
		end else begin
			ov_q <= ov_set || (ov_q && !out_ch.ready);
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						cur_q <= q_cmd;
						idx_q <= '0;
						if (q_cmd.flush && cnt_q != '0) begin
							st_q <= B_FL1;
						end else if (q_cmd.store) begin
							cnt_q <= q_cmd.flush ? CW'(1) : cnt_q + CW'(1);
							st_q <= q_cmd.last ? B_FL2 : B_IDLE;
						end else begin
							if (q_cmd.clear) cnt_q <= '0;
							st_q <= q_cmd.emit ? B_EMIT : B_IDLE;
						end
					end
				end
				B_FL1: begin
					if (out_free) begin
						och_q <= hold_q[idx_q];
						orep_q <= 1'b0;
						oend_q <= last_item && !cur_q.emit && !(cur_q.store && cur_q.last);
						ose_q <= last_item && !cur_q.emit && !cur_q.store && cur_q.last;
						if (last_item) begin
							cnt_q <= '0;
							st_q <= cur_q.store ? B_STORE : (cur_q.emit ? B_EMIT : B_IDLE);
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				B_STORE: begin
					cnt_q <= CW'(1);
					idx_q <= '0;
					st_q <= cur_q.last ? B_FL2 : B_IDLE;
				end
				B_EMIT: begin
					if (out_free) begin
						och_q <= cur_q.ch;
						orep_q <= cur_q.rep;
						oend_q <= 1'b1;
						ose_q <= cur_q.last;
						st_q <= B_IDLE;
					end
				end
				B_FL2: begin
					if (out_free) begin
						och_q <= hold_q[idx_q];
						orep_q <= 1'b0;
						oend_q <= last_item;
						ose_q <= last_item;
						if (last_item) begin
							cnt_q <= '0;
							st_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/html_entity_decoder.sv
`default_nettype none
// An accepted beat is written into the queue, popped into the back end's command register
// and then loaded into the output register. A plain character or a replacement passes the
// idle and emit states of the back end, a held character only idle. The pending buffer sends
// its characters one per cycle while the output register is free; a 2-entry queue parts
// front and back. Reset clears all control state; held characters need no clearing.
module html_entity_decoder #(
	parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hed_in_if.sink    in_ch,
	hed_out_if.source out_ch
);
	import hed_pkg::*;

	hed_cmd_t f_cmd, q_cmd;
	logic     f_valid, f_ready, q_valid, q_pop;

	hed_front #(.MAX_SPAN(MAX_SPAN)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	hed_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_cmd(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_cmd(q_cmd), .rd_valid(q_valid), .rd_pop(q_pop)
	);

	hed_back #(.MAX_SPAN(MAX_SPAN)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch)
	);

`ifndef SYNTH
	a_rep_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.was_replaced |-> out_ch.run_end && out_ch.char_out != 16'd0)
		else $error("replacement not a single nonzero beat");

	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stream_end_out |-> out_ch.run_end)
		else $error("stream end without run end");

	a_pop_queue: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && f_ready && !q_pop |=> q_valid)
		else $error("queue lost a command");
`endif

endmodule

`default_nettype wire

### tb/hed_tb_pkg.sv
package hed_tb_pkg;

	typedef struct packed {
		logic [15:0] ch;
		logic        rep;
		logic        run_end;
		logic        stream_end;
	} decoded_char_t;

endpackage

### tb/html_entity_decoder_tb.sv
`default_nettype none

module html_entity_decoder_tb;
	import hed_pkg::*;
	import hed_tb_pkg::*;

	localparam int SPAN = MAX_SPAN_DEF;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;

	hed_in_if in_ch ();
	hed_out_if out_ch ();

	html_entity_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	decoded_char_t expected_chars[$];
	logic [15:0] held_chars[SPAN];
	int held_count;
	bit holding_ref;

	int mismatches;
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int quiet_cycles;
	bit done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_blank(logic [15:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit name_equals(string nm, int len);
		if (nm.len() != len) return 1'b0;
		for (int i = 0; i < len; i++) begin
			if (held_chars[i + 1] != {8'd0, nm[i]}) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] decode_reference(int len);
		string latin[96] = '{
			"nbsp", "iexcl", "cent", "pound", "curren", "yen", "brvbar", "sect", "uml",
			"copy", "ordf", "laquo", "not", "shy", "reg", "macr", "deg", "plusmn", "sup2",
			"sup3", "acute", "micro", "para", "middot", "cedil", "sup1", "ordm", "raquo",
			"frac14", "frac12", "frac34", "iquest", "Agrave", "Aacute", "Acirc", "Atilde",
			"Auml", "Aring", "AElig", "Ccedil", "Egrave", "Eacute", "Ecirc", "Euml",
			"Igrave", "Iacute", "Icirc", "Iuml", "ETH", "Ntilde", "Ograve", "Oacute",
			"Ocirc", "Otilde", "Ouml", "times", "Oslash", "Ugrave", "Uacute", "Ucirc",
			"Uuml", "Yacute", "THORN", "szlig", "agrave", "aacute", "acirc", "atilde",
			"auml", "aring", "aelig", "ccedil", "egrave", "eacute", "ecirc", "euml",
			"igrave", "iacute", "icirc", "iuml", "eth", "ntilde", "ograve", "oacute",
			"ocirc", "otilde", "ouml", "divide", "oslash", "ugrave", "uacute", "ucirc",
			"uuml", "yacute", "thorn", "yuml"};
		string extra[11] = '{"quot", "amp", "apos", "lt", "rt", "ndash", "mdash", "laquo",
			"raquo", "lsquo", "rsquo"};
		logic [15:0] extra_val[11] = '{16'd34, 16'd38, 16'd39, 16'd60, 16'd62, 16'd8211,
			16'd8212, 16'd34, 16'd34, 16'd8216, 16'd8217};
		int i;
		int value;
		bit neg;
		if (len > 0 && held_chars[1] == CH_HASH) begin
			i = 1;
			value = 0;
			neg = 1'b0;
			while (i < len && is_blank(held_chars[i + 1])) i++;
			if (i < len && (held_chars[i + 1] == CH_PLUS || held_chars[i + 1] == CH_MINUS)) begin
				neg = held_chars[i + 1] == CH_MINUS;
				i++;
			end
			while (i < len && held_chars[i + 1] >= CH_ZERO && held_chars[i + 1] <= CH_NINE) begin
				value = value * 10 + int'(held_chars[i + 1] - CH_ZERO);
				if (value > 'h10000) value = 'h10000;
				i++;
			end
			if (!neg && value >= 1 && value < 'hFFFE) return value[15:0];
			return 16'd0;
		end
		for (int k = 0; k < 96; k++) if (name_equals(latin[k], len)) return 16'(160 + k);
		for (int k = 0; k < 11; k++) if (name_equals(extra[k], len)) return extra_val[k];
		return 16'd0;
	endfunction

	function automatic void push_char(ref decoded_char_t run[$], input logic [15:0] c,
		input bit rep);
		decoded_char_t d;
		d = '{ch: c, rep: rep, run_end: 1'b0, stream_end: 1'b0};
		run.push_back(d);
	endfunction

	function automatic void flush_held(ref decoded_char_t run[$]);
		for (int i = 0; i < held_count; i++) push_char(run, held_chars[i], 1'b0);
		held_count = 0;
		holding_ref = 1'b0;
	endfunction

	function automatic void predict_decode(logic [15:0] c, bit last);
		decoded_char_t run[$];
		logic [15:0] code;
		if (holding_ref && held_count > 0) begin
			if (c == CH_SEMI) begin
				code = decode_reference(held_count - 1);
				if (code != 16'd0) begin
					push_char(run, code, 1'b1);
					held_count = 0;
					holding_ref = 1'b0;
				end else begin
					flush_held(run);
					push_char(run, c, 1'b0);
				end
			end else if (c == CH_AMP) begin
				flush_held(run);
				held_chars[0] = c;
				held_count = 1;
				holding_ref = 1'b1;
			end else if (held_count >= SPAN) begin
				flush_held(run);
				push_char(run, c, 1'b0);
			end else begin
				held_chars[held_count] = c;
				held_count++;
			end
		end else begin
			held_count = 0;
			holding_ref = 1'b0;
			if (c == CH_AMP) begin
				held_chars[0] = c;
				held_count = 1;
				holding_ref = 1'b1;
			end else begin
				push_char(run, c, 1'b0);
			end
		end
		if (last) flush_held(run);
		if (run.size() > 0) begin
			run[$].run_end = 1'b1;
			run[$].stream_end = last;
		end
		foreach (run[i]) expected_chars.push_back(run[i]);
	endfunction

	task automatic send_char(logic [15:0] c, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.stream_end_in <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_decode(c, last);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit last);
		for (int i = 0; i < s.len(); i++) send_char({8'd0, s[i]}, last && i == s.len() - 1);
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (expected_chars.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] random_char();
		case ($urandom_range(9))
			0: return 16'($urandom_range(65535));
			1: return CH_AMP;
			2: return CH_SEMI;
			3: return CH_HASH;
			4: return 16'($urandom_range(CH_ZERO, CH_NINE));
			5: return 16'($urandom_range(13, 9));
			default: return 16'($urandom_range(126, 32));
		endcase
	endfunction

	task automatic send_random_reference();
		string names[10] = '{"amp", "lt", "rt", "quot", "mdash", "yuml", "AElig", "nbsp",
			"eacute", "rsquo"};
		string body;
		bit last;
		last = $urandom_range(9) == 0;
		case ($urandom_range(3))
			0: body = names[$urandom_range(9)];
			1: body = $sformatf("#%0d", $urandom_range(70000));
			2: body = $sformatf("# +%0d", $urandom_range(300));
			default: begin
				body = "";
				repeat ($urandom_range(9)) body = {body, string'(8'($urandom_range(122, 97)))};
			end
		endcase
		if ($urandom_range(4) == 0) send_char(random_char(), 1'b0);
		send_text({"&", body, ";"}, last);
	endtask

	task automatic test_directed();
		send_char(16'h0000, 1'b0);
		send_char(16'hFFFF, 1'b0);
		send_text("&amp;&rt;&mdash;&yuml;&nbsp;", 1'b0);
		send_text("&#65;&# -5;&#0;&#65533;&#65534;&#99999999;&AMP;", 1'b0);
		send_text("&&lt;&abcdefgh;&abcdefghij", 1'b0);
		send_char(16'h5555, 1'b0);
		send_char(16'hAAAA, 1'b1);
		send_text("&quo", 1'b1);
		send_text("x", 1'b1);
		drain();
	endtask

	task automatic test_random_text(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(3) == 0) send_char(random_char(), $urandom_range(19) == 0);
			else send_random_reference();
		end
		send_char(16'h0041, 1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 300;
		for (int n = 0; n < 2; n++) send_text("&#9;x&lt;", 1'b0);
		send_text("&eacute", 1'b1);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		decoded_char_t got;
		decoded_char_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{ch: out_ch.char_out, rep: out_ch.was_replaced, run_end: out_ch.run_end,
				stream_end: out_ch.stream_end_out};
			if (expected_chars.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected beat %p", got);
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !done) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.char_in = 16'd0;
		in_ch.stream_end_in = 1'b0;
		out_ch.ready = 1'b0;
		held_count = 0;
		holding_ref = 1'b0;
		mismatches = 0;
		errors = 0;
		hold_off_cycles = 0;
		quiet_cycles = 0;
		done = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 47;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_text(3);
		send_idle_pct = 47;
		recv_idle_pct = 16;
		test_backpressure();
		test_random_text(3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(3);
		done = 1'b1;
		if (errors == 0 && expected_chars.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
